[rtl/palette_fade_rotate_engine_defines.svh]
// Assertion macros for the palette fade and rotate engine.
// Used by files that include this header; expects aclk and aresetn in scope.
`ifndef PALETTE_FADE_ROTATE_ENGINE_DEFINES_SVH
`define PALETTE_FADE_ROTATE_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define PFR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pfr assertion failed");
// Next-cycle implication, disabled during reset
`define PFR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pfr assertion failed");
`else
`define PFR_ASSERT_IMP(lbl, ante, cons)
`define PFR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/pfr_pkg.sv]
// Shared types, constants and helpers of the palette fade and rotate engine.
// No dependencies; imported by the scaler and the top level.
`default_nettype none

package pfr_pkg;

    localparam int ENTRY_COUNT = 256;
    localparam int ADDR_W      = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRY_COUNT - 1);
    localparam logic [5:0]        LEVEL_MAX = 6'd63;

    // Command codes carried in s_tuser
    typedef enum logic [2:0] {
        MODE_WRITE  = 3'd0,
        MODE_READ   = 3'd1,
        MODE_FADE   = 3'd2,
        MODE_LIGHT  = 3'd3,
        MODE_ROTATE = 3'd4,
        MODE_CLEAR  = 3'd5
    } mode_t;

    // One palette entry, red in the top bits
    typedef struct packed {
        logic [5:0] red;
        logic [5:0] green;
        logic [5:0] blue;
    } entry_t;

    function automatic logic idx_in_range(logic [7:0] idx);
        return (32'(idx) < ENTRY_COUNT);
    endfunction

    function automatic logic [ADDR_W-1:0] to_addr(logic [7:0] idx);
        return ADDR_W'(idx);
    endfunction

endpackage

`default_nettype wire

[rtl/palette_fade_rotate_engine.sv]
// Top level of the palette fade and rotate engine: sequencer, valid bits, output register.
// Depends on pfr_pkg, pfr_ram, pfr_scaler and palette_fade_rotate_engine_defines.svh.
//
//  channel  | dir | tdata                                          | tuser
//  ---------+-----+------------------------------------------------+--------------
//  s_ (cmd) | in  | index, range_end, red_in, green_in, blue_in,   | mode
//           |     | amount                                         |
//  m_ (res) | out | red_out, green_out, blue_out                   | is_read_data
//
// Write, clear, unused codes and fade with amount 32 or more finish without a sweep; read
// waits for the RAM read; fade and light-up sweep every entry (one entry a cycle through the
// scaler and the single write port); rotate moves each entry of the span, or only copies the
// end entry when index >= range_end.
// Reset clears every valid bit at once, so the palette reads as zero with no sweep.
// s_tready is high only while idle; a result waits in the output register.
`default_nettype none
`include "palette_fade_rotate_engine_defines.svh"

module palette_fade_rotate_engine
    import pfr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] index, [15:8] range_end, [21:16] red_in, [27:22] green_in,
    // [33:28] blue_in, [39:34] amount
    input  wire logic [39:0] s_tdata,
    // [2:0] mode
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] red_out, [15:8] green_out, [23:16] blue_out
    output logic      [23:0] m_tdata,
    // [0] is_read_data
    output logic      [0:0]  m_tuser
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SWEEP,
        ST_ROT_RUN,
        ST_DRAIN,
        ST_ROT_FIX,
        ST_READ_WAIT,
        ST_DONE
    } state_t;

    state_t                   state_reg,      state_next;
    mode_t                    cmd_mode_reg,   cmd_mode_next;
    logic [7:0]               cmd_index_reg,  cmd_index_next;
    logic [7:0]               cmd_end_reg,    cmd_end_next;
    entry_t                   cmd_entry_reg,  cmd_entry_next;
    logic [5:0]               cmd_amount_reg, cmd_amount_next;
    logic [ADDR_W-1:0]        rd_ptr_reg,     rd_ptr_next;
    logic                     wb_valid_reg,   wb_valid_next;
    logic                     wb_save_reg,    wb_save_next;
    logic [ADDR_W-1:0]        wb_addr_reg,    wb_addr_next;
    entry_t                   saved_reg,      saved_next;
    logic                     rd_valid_reg,   rd_valid_next;
    logic [ENTRY_COUNT-1:0]   valid_reg,      valid_next;
    logic [23:0]              res_data_reg,   res_data_next;
    logic                     res_read_reg,   res_read_next;
    logic                     m_tvalid_reg,   m_tvalid_next;
    logic [23:0]              m_tdata_reg,    m_tdata_next;
    logic                     m_tuser_reg,    m_tuser_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    entry_t            ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    entry_t            ram_rdata;
    entry_t            rd_level;
    entry_t            scaled;

    pfr_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRY_COUNT)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Never-written entries read as zero
    assign rd_level = rd_valid_reg ? ram_rdata : entry_t'('0);

    pfr_scaler u_scaler (
        .level_in  (rd_level),
        .amount    (cmd_amount_reg),
        .light     (cmd_mode_reg == MODE_LIGHT),
        .level_out (scaled)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Sequencer and next-state logic
    always_comb begin
        state_next      = state_reg;
        cmd_mode_next   = cmd_mode_reg;
        cmd_index_next  = cmd_index_reg;
        cmd_end_next    = cmd_end_reg;
        cmd_entry_next  = cmd_entry_reg;
        cmd_amount_next = cmd_amount_reg;
        rd_ptr_next     = rd_ptr_reg;
        wb_valid_next   = 1'b0;
        wb_save_next    = wb_save_reg;
        wb_addr_next    = wb_addr_reg;
        saved_next      = saved_reg;
        valid_next      = valid_reg;
        res_data_next   = res_data_reg;
        res_read_next   = res_read_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        ram_we          = 1'b0;
        ram_waddr       = wb_addr_reg;
        ram_wdata       = rd_level;
        ram_raddr       = rd_ptr_reg;

        // Drop the result once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // Write back the entry read last cycle, or capture it for rotate
        if (wb_valid_reg) begin
            if (wb_save_reg) begin
                saved_next = rd_level;
            end else begin
                ram_we                  = 1'b1;
                ram_waddr               = wb_addr_reg;
                ram_wdata               = (cmd_mode_reg == MODE_ROTATE) ? rd_level : scaled;
                valid_next[wb_addr_reg] = 1'b1;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_mode_next   = mode_t'(s_tuser);
                    cmd_index_next  = s_tdata[7:0];
                    cmd_end_next    = s_tdata[15:8];
                    cmd_entry_next  = entry_t'({s_tdata[21:16], s_tdata[27:22],
                                                s_tdata[33:28]});
                    cmd_amount_next = s_tdata[39:34];
                    state_next      = ST_START;
                end
            end
            ST_START: begin
                res_data_next = '0;
                res_read_next = 1'b0;
                state_next    = ST_DONE;
                unique case (cmd_mode_reg)
                    MODE_WRITE: begin
                        if (idx_in_range(cmd_index_reg)) begin
                            ram_we    = 1'b1;
                            ram_waddr = to_addr(cmd_index_reg);
                            ram_wdata = cmd_entry_reg;
                            valid_next[to_addr(cmd_index_reg)] = 1'b1;
                        end
                    end
                    MODE_READ: begin
                        res_read_next = 1'b1;
                        ram_raddr     = to_addr(cmd_index_reg);
                        if (idx_in_range(cmd_index_reg)) begin
                            state_next = ST_READ_WAIT;
                        end
                    end
                    MODE_FADE: begin
                        if (!cmd_amount_reg[5]) begin
                            rd_ptr_next = '0;
                            state_next  = ST_SWEEP;
                        end
                    end
                    MODE_LIGHT: begin
                        rd_ptr_next = '0;
                        state_next  = ST_SWEEP;
                    end
                    MODE_ROTATE: begin
                        if (idx_in_range(cmd_index_reg) && idx_in_range(cmd_end_reg)) begin
                            // Read the last entry of the span and keep it aside
                            ram_raddr     = to_addr(cmd_end_reg);
                            wb_valid_next = 1'b1;
                            wb_save_next  = 1'b1;
                            if (cmd_end_reg > cmd_index_reg) begin
                                rd_ptr_next = to_addr(cmd_end_reg) - ADDR_W'(1);
                                state_next  = ST_ROT_RUN;
                            end else begin
                                state_next  = ST_DRAIN;
                            end
                        end
                    end
                    MODE_CLEAR: begin
                        valid_next = '0;
                    end
                    default: begin
                    end
                endcase
            end
            ST_SWEEP: begin
                // Read one entry a cycle; it is scaled and written back next cycle
                ram_raddr     = rd_ptr_reg;
                wb_valid_next = 1'b1;
                wb_save_next  = 1'b0;
                wb_addr_next  = rd_ptr_reg;
                if (rd_ptr_reg == LAST_ADDR) begin
                    state_next = ST_DRAIN;
                end else begin
                    rd_ptr_next = rd_ptr_reg + ADDR_W'(1);
                end
            end
            ST_ROT_RUN: begin
                // Move entries up by one, from the top of the span downward
                ram_raddr     = rd_ptr_reg;
                wb_valid_next = 1'b1;
                wb_save_next  = 1'b0;
                wb_addr_next  = rd_ptr_reg + ADDR_W'(1);
                if (rd_ptr_reg == to_addr(cmd_index_reg)) begin
                    state_next = ST_DRAIN;
                end else begin
                    rd_ptr_next = rd_ptr_reg - ADDR_W'(1);
                end
            end
            ST_DRAIN: begin
                state_next = (cmd_mode_reg == MODE_ROTATE) ? ST_ROT_FIX : ST_DONE;
            end
            ST_ROT_FIX: begin
                // Old last entry goes to the first slot of the span
                ram_we    = 1'b1;
                ram_waddr = to_addr(cmd_index_reg);
                ram_wdata = saved_reg;
                valid_next[to_addr(cmd_index_reg)] = 1'b1;
                state_next = ST_DONE;
            end
            ST_READ_WAIT: begin
                res_data_next = {rd_level.blue, 2'b00, rd_level.green, 2'b00,
                                 rd_level.red, 2'b00};
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                // Hand the result over once the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_data_reg;
                    m_tuser_next  = res_read_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        rd_valid_next = valid_reg[ram_raddr];
    end

    // State, control and payload registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wb_valid_reg <= 1'b0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wb_valid_reg <= wb_valid_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        cmd_mode_reg   <= cmd_mode_next;
        cmd_index_reg  <= cmd_index_next;
        cmd_end_reg    <= cmd_end_next;
        cmd_entry_reg  <= cmd_entry_next;
        cmd_amount_reg <= cmd_amount_next;
        rd_ptr_reg     <= rd_ptr_next;
        wb_save_reg    <= wb_save_next;
        wb_addr_reg    <= wb_addr_next;
        saved_reg      <= saved_next;
        rd_valid_reg   <= rd_valid_next;
        res_data_reg   <= res_data_next;
        res_read_reg   <= res_read_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    // No write-back may be pending while the block takes a new item
    `PFR_ASSERT_IMP(a_idle_no_wb, s_tready, !wb_valid_reg)
    // An accepted item is dispatched in the next cycle
    `PFR_ASSERT_NXT(a_accept_start, s_tvalid && s_tready, state_reg == ST_START)
    // Entry capture only happens for rotate
    `PFR_ASSERT_IMP(a_save_rotate, wb_valid_reg && wb_save_reg, cmd_mode_reg == MODE_ROTATE)
    // Completion-only results carry zero levels
    `PFR_ASSERT_IMP(a_zero_done, m_tvalid && !m_tuser[0], m_tdata == '0)

endmodule

`default_nettype wire

[rtl/pfr_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module pfr_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/pfr_scaler.sv]
// Shared level scaler: fades one entry toward black or lights it toward 63.
// Depends on pfr_pkg.
`default_nettype none

module pfr_scaler
    import pfr_pkg::*;
(
    input  wire entry_t     level_in,
    input  wire logic [5:0] amount,
    input  wire logic       light,
    output entry_t          level_out
);

    // Fade: (v*a)>>5. Light: v + (a*(63-v))>>5, which never passes 63 for a < 32;
    // a weight of 32 or more saturates the channel.
    function automatic logic [5:0] scale_ch(logic [5:0] v, logic [5:0] amt, logic lt);
        logic [5:0]  x;
        logic [10:0] p;
        logic [5:0]  q;
        x = lt ? (LEVEL_MAX - v) : v;
        p = 11'(x) * 11'(amt[4:0]);
        q = p[10:5];
        if (lt && amt[5]) begin
            return LEVEL_MAX;
        end else if (lt) begin
            return v + q;
        end
        return q;
    endfunction

    // Scale the three channels side by side
    always_comb begin
        level_out.red   = scale_ch(level_in.red,   amount, light);
        level_out.green = scale_ch(level_in.green, amount, light);
        level_out.blue  = scale_ch(level_in.blue,  amount, light);
    end

endmodule

`default_nettype wire

[test/palette_fade_rotate_engine_test.sv]
// Self-checking testbench for palette_fade_rotate_engine: directed and random command items,
// a shadow palette that predicts every result, and random stalls on both stream channels.
// Depends on pfr_pkg and the engine RTL only.
`timescale 1ns / 100ps

module palette_fade_rotate_engine_test
    import pfr_pkg::*;
();

    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int SETTLE_CYCLES  = ENTRY_COUNT + 16;

    // One command item as the test sees it
    typedef struct {
        mode_t      mode;
        logic [7:0] index;
        logic [7:0] range_end;
        logic [5:0] red;
        logic [5:0] green;
        logic [5:0] blue;
        logic [5:0] amount;
    } cmd_t;

    // One result item
    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       is_read;
    } result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = MODE_WRITE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;

    entry_t  palette_shadow [ENTRY_COUNT];
    result_t pending_results [$];

    int error_count    = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int holdoff_left   = 0;
    bit holdoff_req    = 1'b0;

    palette_fade_rotate_engine DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Drive result-side ready: long hold-off when requested, random stalls otherwise
    always @(negedge aclk) begin
        if (holdoff_req) begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoff_req  = 1'b0;
        end
        if (holdoff_left > 0) begin
            holdoff_left = holdoff_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result item with none expected: tdata %h tuser %b", m_tdata, m_tuser);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[7:0] !== want.red) begin
                    $error("red_out: expected %0d, got %0d", want.red, m_tdata[7:0]);
                    error_count++;
                end
                if (m_tdata[15:8] !== want.green) begin
                    $error("green_out: expected %0d, got %0d", want.green, m_tdata[15:8]);
                    error_count++;
                end
                if (m_tdata[23:16] !== want.blue) begin
                    $error("blue_out: expected %0d, got %0d", want.blue, m_tdata[23:16]);
                    error_count++;
                end
                if (m_tuser[0] !== want.is_read) begin
                    $error("is_read_data: expected %0d, got %0d", want.is_read, m_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    // Fade one level toward black by amt/32
    function automatic logic [5:0] fade_level(logic [5:0] v, logic [5:0] amt);
        int prod;
        prod = int'(v) * int'(amt);
        return 6'(prod >> 5);
    endfunction

    // Blend one level toward full by amt/32, clamp at full
    function automatic logic [5:0] lift_level(logic [5:0] v, logic [5:0] amt);
        int num;
        num = int'(v) * (32 - int'(amt)) + int'(LEVEL_MAX) * int'(amt);
        num = num >> 5;
        return (num > int'(LEVEL_MAX)) ? LEVEL_MAX : 6'(num);
    endfunction

    // Apply one command to the shadow palette and return its result
    function automatic result_t apply_palette_cmd(cmd_t c);
        result_t res;
        entry_t  saved;
        int      i;
        res = '{red: 8'd0, green: 8'd0, blue: 8'd0, is_read: 1'b0};
        case (c.mode)
            MODE_WRITE: begin
                if (int'(c.index) < ENTRY_COUNT)
                    palette_shadow[c.index] = '{red: c.red, green: c.green, blue: c.blue};
            end
            MODE_READ: begin
                if (int'(c.index) < ENTRY_COUNT) begin
                    res.red   = {palette_shadow[c.index].red, 2'b00};
                    res.green = {palette_shadow[c.index].green, 2'b00};
                    res.blue  = {palette_shadow[c.index].blue, 2'b00};
                end
                res.is_read = 1'b1;
            end
            MODE_FADE: begin
                if (c.amount < 6'd32) begin
                    for (i = 0; i < ENTRY_COUNT; i++) begin
                        palette_shadow[i].red   = fade_level(palette_shadow[i].red, c.amount);
                        palette_shadow[i].green = fade_level(palette_shadow[i].green, c.amount);
                        palette_shadow[i].blue  = fade_level(palette_shadow[i].blue, c.amount);
                    end
                end
            end
            MODE_LIGHT: begin
                for (i = 0; i < ENTRY_COUNT; i++) begin
                    palette_shadow[i].red   = lift_level(palette_shadow[i].red, c.amount);
                    palette_shadow[i].green = lift_level(palette_shadow[i].green, c.amount);
                    palette_shadow[i].blue  = lift_level(palette_shadow[i].blue, c.amount);
                end
            end
            MODE_ROTATE: begin
                // index above range_end shifts nothing and just copies the end entry
                if (int'(c.index) < ENTRY_COUNT && int'(c.range_end) < ENTRY_COUNT) begin
                    saved = palette_shadow[c.range_end];
                    for (i = int'(c.range_end); i > int'(c.index); i--)
                        palette_shadow[i] = palette_shadow[i - 1];
                    palette_shadow[c.index] = saved;
                end
            end
            MODE_CLEAR: begin
                for (i = 0; i < ENTRY_COUNT; i++)
                    palette_shadow[i] = '0;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic cmd_t make_cmd(mode_t m, int idx, int last, int r, int g, int b,
                                      int amt);
        cmd_t c;
        c.mode      = m;
        c.index     = 8'(idx);
        c.range_end = 8'(last);
        c.red       = 6'(r);
        c.green     = 6'(g);
        c.blue      = 6'(b);
        c.amount    = 6'(amt);
        return c;
    endfunction

    // Random command, weighted toward single-entry traffic around a hot window
    function automatic cmd_t random_cmd();
        cmd_t c;
        int   pick;
        pick        = $urandom_range(99);
        c.mode      = (pick < 34) ? MODE_WRITE :
                      (pick < 68) ? MODE_READ :
                      (pick < 76) ? MODE_FADE :
                      (pick < 84) ? MODE_LIGHT :
                      (pick < 95) ? MODE_ROTATE : MODE_CLEAR;
        c.index     = $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
        c.range_end = ($urandom_range(3) != 0) ? 8'($urandom_range(31)) : 8'($urandom_range(255));
        c.red       = 6'($urandom_range(63));
        c.green     = 6'($urandom_range(63));
        c.blue      = 6'($urandom_range(63));
        c.amount    = 6'($urandom_range(63));
        return c;
    endfunction

    // Offer one item after a random gap, hold it until accepted, then predict its result
    task automatic send_cmd(cmd_t c);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c.amount, c.blue, c.green, c.red, c.range_end, c.index};
        s_tuser  <= c.mode;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pending_results.push_back(apply_palette_cmd(c));
    endtask

    // Drop valid and wait for every outstanding result
    task automatic idle_until_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_write_read_extremes();
        send_cmd(make_cmd(MODE_READ, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(MODE_WRITE, 0, 0, 63, 63, 63, 0));
        send_cmd(make_cmd(MODE_WRITE, 255, 255, 42, 21, 63, 63));
        send_cmd(make_cmd(MODE_WRITE, 128, 0, 1, 2, 3, 0));
        send_cmd(make_cmd(MODE_READ, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(MODE_READ, 255, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(MODE_READ, 128, 0, 0, 0, 0, 0));
    endtask

    // Amount 32 and above must leave the palette alone
    task automatic test_fade_levels();
        send_cmd(make_cmd(MODE_FADE, 0, 0, 0, 0, 0, 31));
        send_cmd(make_cmd(MODE_FADE, 0, 0, 0, 0, 0, 63));
        send_cmd(make_cmd(MODE_READ, 255, 0, 0, 0, 0, 0));
    endtask

    task automatic test_light_up_levels();
        send_cmd(make_cmd(MODE_LIGHT, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(MODE_LIGHT, 0, 0, 0, 0, 0, 16));
        send_cmd(make_cmd(MODE_READ, 128, 0, 0, 0, 0, 0));
    endtask

    // Full span, empty span, and a span with index above range_end
    task automatic test_rotate_spans();
        send_cmd(make_cmd(MODE_ROTATE, 0, 255, 0, 0, 0, 0));
        send_cmd(make_cmd(MODE_READ, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(MODE_ROTATE, 5, 5, 0, 0, 0, 0));
        send_cmd(make_cmd(MODE_ROTATE, 200, 3, 0, 0, 0, 0));
        send_cmd(make_cmd(MODE_READ, 200, 0, 0, 0, 0, 0));
    endtask

    // Saturating light-up, fade to black, then clear
    task automatic test_saturate_and_clear();
        send_cmd(make_cmd(MODE_LIGHT, 0, 0, 0, 0, 0, 63));
        send_cmd(make_cmd(MODE_READ, 7, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(MODE_FADE, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(MODE_READ, 7, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(MODE_WRITE, 9, 0, 33, 17, 5, 0));
        send_cmd(make_cmd(MODE_CLEAR, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(MODE_READ, 9, 0, 0, 0, 0, 0));
        idle_until_drained();
    endtask

    // Hold off the result side while items keep coming, so the input stalls
    task automatic test_backpressure_fill();
        int n;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge aclk);
        holdoff_req = 1'b1;
        for (n = 0; n < 10; n++)
            send_cmd(random_cmd());
        idle_until_drained();
    endtask

    // Pause the sender mid-stream until every result is back
    task automatic test_drain_pause();
        int n;
        send_idle_pct  = 25;
        recv_stall_pct = 25;
        for (n = 0; n < 5; n++)
            send_cmd(random_cmd());
        idle_until_drained();
        for (n = 0; n < 5; n++)
            send_cmd(random_cmd());
        idle_until_drained();
    endtask

    task automatic test_random_mix(int count, int idle_pct, int stall_pct);
        int n;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (n = 0; n < count; n++)
            send_cmd(random_cmd());
    endtask

    initial begin
        foreach (palette_shadow[i])
            palette_shadow[i] = '0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        test_write_read_extremes();
        test_fade_levels();
        test_light_up_levels();
        test_rotate_spans();
        test_saturate_and_clear();
        test_backpressure_fill();
        test_drain_pause();
        test_random_mix(150, 0, 0);
        test_random_mix(150, 63, 0);
        test_random_mix(150, 0, 63);
        test_random_mix(150, 25, 25);

        // Let any stray result show up before the verdict
        idle_until_drained();
        recv_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
